### src/rktf_pkg.sv
// Package for the tape record framer: job descriptor, sequencer slot codes,
// register indexes and format constants. No dependencies.
`timescale 1ns / 1ps

package rktf_pkg;

   localparam logic [7:0] SYNC_BYTE = 8'hE6;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOAD_ADDRESS = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BYTE_COUNT   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TAPE_VARIANT = 2'd2;

   localparam logic VARIANT_ADDITIVE = 1'b0;

   typedef struct packed {
      logic [7:0]  payload_byte;
      logic        first;
      logic        last;
      logic        tape_variant;
      logic [15:0] load_address;
      logic [15:0] end_address;
      logic [15:0] checksum;
   } job_type;

   typedef enum logic [11:0] {
      SLOT_LEADER = 12'b0000_0000_0001,
      SLOT_SYNC   = 12'b0000_0000_0010,
      SLOT_LA_HI  = 12'b0000_0000_0100,
      SLOT_LA_LO  = 12'b0000_0000_1000,
      SLOT_EA_HI  = 12'b0000_0001_0000,
      SLOT_EA_LO  = 12'b0000_0010_0000,
      SLOT_DATA   = 12'b0000_0100_0000,
      SLOT_PAD0   = 12'b0000_1000_0000,
      SLOT_PAD1   = 12'b0001_0000_0000,
      SLOT_SYNC2  = 12'b0010_0000_0000,
      SLOT_CK_HI  = 12'b0100_0000_0000,
      SLOT_CK_LO  = 12'b1000_0000_0000
   } slot_type;

endpackage

### src/rktf_front.sv
// Front end: accepts payload bytes, tracks record position and checksum,
// and builds one job per byte. Depends on rktf_pkg.
`timescale 1ns / 1ps

module rktf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        payload_byte,
   input  logic [15:0]       load_address,
   input  logic [15:0]       byte_count,
   input  logic              tape_variant,
   output rktf_pkg::job_type job
);

   logic [15:0] position_ff, position_in;
   logic [15:0] checksum_ff, checksum_in;
   logic        last;
   logic [15:0] ck_next;
   logic [7:0]  ck_lo_sum;

   always_comb begin
      last      = (position_ff == (byte_count - 16'd1));
      ck_lo_sum = checksum_ff[7:0] + payload_byte;
      if (tape_variant == rktf_pkg::VARIANT_ADDITIVE) begin
         if (last) begin
            ck_next = {checksum_ff[15:8], ck_lo_sum};
         end else begin
            ck_next = checksum_ff + {payload_byte, payload_byte};
         end
      end else if (position_ff[0]) begin
         ck_next = checksum_ff ^ {payload_byte, 8'h00};
      end else begin
         ck_next = checksum_ff ^ {8'h00, payload_byte};
      end

      job.payload_byte = payload_byte;
      job.first        = (position_ff == 16'd0);
      job.last         = last;
      job.tape_variant = tape_variant;
      job.load_address = load_address;
      job.end_address  = load_address + byte_count - 16'd1;
      job.checksum     = ck_next;

      position_in = position_ff;
      checksum_in = checksum_ff;
      if (accept) begin
         position_in = last ? 16'd0 : position_ff + 16'd1;
         checksum_in = last ? 16'd0 : ck_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= 16'd0;
         checksum_ff <= 16'd0;
      end else begin
         position_ff <= position_in;
         checksum_ff <= checksum_in;
      end
   end

endmodule

### src/rktf_job_fifo.sv
// Two-entry job queue between front and back end. Depends on rktf_pkg.
`timescale 1ns / 1ps

module rktf_job_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rktf_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output rktf_pkg::job_type head_job,
   output logic [1:0]        count
);

   rktf_pkg::job_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign valid    = (count_ff != 2'd0);
   assign head_job = mem_ff[rd_ptr_ff];
   assign count    = count_ff;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### src/rktf_back.sv
// Back end: expands each job into its run-length results, one per cycle
// unless the output register stays full. Depends on rktf_pkg.
`timescale 1ns / 1ps

module rktf_back #(
   parameter int LEADER_LENGTH = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  rktf_pkg::job_type job,
   output logic              job_pop,
   input  logic              out_pop,
   output logic              out_valid,
   output logic [7:0]        tape_byte,
   output logic [8:0]        repeat_count,
   output logic              last_of_run,
   output logic              record_done
);

   rktf_pkg::slot_type slot_ff, slot_in, cur_slot, next_slot;
   logic       busy_ff, busy_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic [8:0] count_ff, count_in;
   logic       lor_ff, lor_in;
   logic       done_ff, done_in;
   logic       emit;
   logic       final_slot;

   always_comb begin
      cur_slot = busy_ff ? slot_ff
                         : (job.first ? rktf_pkg::SLOT_LEADER : rktf_pkg::SLOT_DATA);
      byte_in    = 8'h00;
      count_in   = 9'd1;
      final_slot = 1'b0;
      next_slot  = rktf_pkg::SLOT_DATA;
      case (cur_slot)
         rktf_pkg::SLOT_LEADER: begin
            count_in  = 9'(LEADER_LENGTH);
            next_slot = rktf_pkg::SLOT_SYNC;
         end
         rktf_pkg::SLOT_SYNC: begin
            byte_in   = rktf_pkg::SYNC_BYTE;
            next_slot = rktf_pkg::SLOT_LA_HI;
         end
         rktf_pkg::SLOT_LA_HI: begin
            byte_in   = job.load_address[15:8];
            next_slot = rktf_pkg::SLOT_LA_LO;
         end
         rktf_pkg::SLOT_LA_LO: begin
            byte_in   = job.load_address[7:0];
            next_slot = rktf_pkg::SLOT_EA_HI;
         end
         rktf_pkg::SLOT_EA_HI: begin
            byte_in   = job.end_address[15:8];
            next_slot = rktf_pkg::SLOT_EA_LO;
         end
         rktf_pkg::SLOT_EA_LO: begin
            byte_in   = job.end_address[7:0];
            next_slot = rktf_pkg::SLOT_DATA;
         end
         rktf_pkg::SLOT_DATA: begin
            byte_in    = job.payload_byte;
            final_slot = !job.last;
            next_slot  = (job.tape_variant == rktf_pkg::VARIANT_ADDITIVE)
                         ? rktf_pkg::SLOT_PAD0 : rktf_pkg::SLOT_CK_HI;
         end
         rktf_pkg::SLOT_PAD0: begin
            next_slot = rktf_pkg::SLOT_PAD1;
         end
         rktf_pkg::SLOT_PAD1: begin
            next_slot = rktf_pkg::SLOT_SYNC2;
         end
         rktf_pkg::SLOT_SYNC2: begin
            byte_in   = rktf_pkg::SYNC_BYTE;
            next_slot = rktf_pkg::SLOT_CK_HI;
         end
         rktf_pkg::SLOT_CK_HI: begin
            byte_in   = job.checksum[15:8];
            next_slot = rktf_pkg::SLOT_CK_LO;
         end
         rktf_pkg::SLOT_CK_LO: begin
            byte_in    = job.checksum[7:0];
            final_slot = 1'b1;
         end
         default: begin
            final_slot = 1'b1;
         end
      endcase
      lor_in  = final_slot;
      done_in = (cur_slot == rktf_pkg::SLOT_CK_LO);

      emit    = job_valid && (!valid_ff || out_pop);
      job_pop = emit && final_slot;
      busy_in = busy_ff;
      slot_in = slot_ff;
      if (emit) begin
         busy_in = !final_slot;
         slot_in = next_slot;
      end
      valid_in = emit || (valid_ff && !out_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         slot_ff  <= rktf_pkg::SLOT_DATA;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         slot_ff  <= slot_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff  <= byte_in;
         count_ff <= count_in;
         lor_ff   <= lor_in;
         done_ff  <= done_in;
      end
   end

   assign out_valid    = valid_ff;
   assign tape_byte    = byte_ff;
   assign repeat_count = count_ff;
   assign last_of_run  = lor_ff;
   assign record_done  = done_ff;

endmodule

### src/rk_tape_record_framer_core.sv
// Top level of the tape record framer: configuration registers, front end,
// job queue and back end. Depends on rktf_pkg, rktf_front, rktf_job_fifo, rktf_back.
//
//   channel  ports                          direction  transaction
//   req      req_push/req_full, payload     in         one payload byte
//   rsp      rsp_empty/rsp_pop, result      out        one run-length result
//   csr      csr_we, csr_index, csr_wdata   in         one register write
//
// Each payload byte yields 1 to 12 results; the back end sends one result per
// cycle while a job is queued, unless the consumer leaves a result unpopped.
// A byte is taken whenever the two-entry job queue has room, so the front end
// runs ahead while the back end or the consumer stalls.
// Synchronous active-high reset clears position, checksum and all queues.
`timescale 1ns / 1ps

module rk_tape_record_framer_core #(
   parameter int LEADER_LENGTH = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [7:0]                           req_payload_byte,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic [7:0]                           rsp_tape_byte,
   output logic [8:0]                           rsp_repeat_count,
   output logic                                 rsp_last_of_run,
   output logic                                 rsp_record_done,
   input  logic                                 csr_we,
   input  logic [rktf_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [15:0]                          csr_wdata
);

   logic [15:0] load_address_ff, load_address_in;
   logic [15:0] byte_count_ff, byte_count_in;
   logic        tape_variant_ff, tape_variant_in;

   rktf_pkg::job_type front_job, head_job;
   logic       accept;
   logic       job_valid, job_pop, out_valid;
   logic [1:0] job_count;

   always_comb begin
      load_address_in = load_address_ff;
      byte_count_in   = byte_count_ff;
      tape_variant_in = tape_variant_ff;
      if (csr_we) begin
         case (csr_index)
            rktf_pkg::CSR_LOAD_ADDRESS: load_address_in = csr_wdata;
            rktf_pkg::CSR_BYTE_COUNT:   byte_count_in   = csr_wdata;
            rktf_pkg::CSR_TAPE_VARIANT: tape_variant_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_address_ff <= 16'h0100;
         byte_count_ff   <= 16'd1;
         tape_variant_ff <= rktf_pkg::VARIANT_ADDITIVE;
      end else begin
         load_address_ff <= load_address_in;
         byte_count_ff   <= byte_count_in;
         tape_variant_ff <= tape_variant_in;
      end
   end

   assign accept    = req_push && !req_full;
   assign rsp_empty = !out_valid;

   rktf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .payload_byte (req_payload_byte),
      .load_address (load_address_ff),
      .byte_count   (byte_count_ff),
      .tape_variant (tape_variant_ff),
      .job          (front_job)
   );

   rktf_job_fifo u_job_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_job (front_job),
      .full     (req_full),
      .pop      (job_pop),
      .valid    (job_valid),
      .head_job (head_job),
      .count    (job_count)
   );

   rktf_back #(
      .LEADER_LENGTH (LEADER_LENGTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .job_valid    (job_valid),
      .job          (head_job),
      .job_pop      (job_pop),
      .out_pop      (rsp_pop),
      .out_valid    (out_valid),
      .tape_byte    (rsp_tape_byte),
      .repeat_count (rsp_repeat_count),
      .last_of_run  (rsp_last_of_run),
      .record_done  (rsp_record_done)
   );

`ifndef SYNTH
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_record_done) |-> (rsp_last_of_run && rsp_repeat_count == 9'd1))
      else $error("record_done without last_of_run");

   a_pop_gives_result: assert property (@(posedge clock) disable iff (reset)
      job_pop |=> !rsp_empty)
      else $error("job retired without a result");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      (job_count == 2'd2) |-> (req_full && !$past(job_count == 2'd2 && !job_pop && accept)))
      else $error("job queue overflow");
`endif

endmodule
